[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, switched off while reset is high
`define CDL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// clocked check that also holds during reset
`define CDL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CDL_ASSERT(label, clk, rst, prop, msg)
`define CDL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[src/cdl_pkg.sv]
// ----------------------------------------------------------------------------
// cdl_pkg
// shared constants, command/status types and helpers of the line drawer
// ----------------------------------------------------------------------------
`default_nettype none

package cdl_pkg;

   localparam int COORD_BITS_DEF      = 16;
   localparam int SLOPE_FRAC_BITS_DEF = 16;

   localparam int DIM_W   = 13;
   localparam int PIX_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 24;

   localparam logic [DIM_W-1:0]   MAX_EXTENT   = 13'd4096;
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
   localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'hFFFFFF;

   // register index map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_START_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_END_X        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_END_Y        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_RGB    = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic setup;     // latch axis and divider operands
      logic div_step;  // one quotient bit, refresh bounds
      logic div_last;  // final quotient bit, commit slope
      logic diff;      // offset along the major axis
      logic mul;       // slope times offset
      logic sum;       // add minor start
      logic load_rsp;  // load the result register
      logic pixel;     // result is a drawn step, not a setup/empty one
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic degenerate;
      logic active;
   } stat_type;

   function automatic logic [DIM_W-1:0] sat_extent(input logic [DIM_W-1:0] v);
      return (v > MAX_EXTENT) ? MAX_EXTENT : v;
   endfunction

endpackage

`default_nettype wire

[src/cdl_regs.sv]
// ----------------------------------------------------------------------------
// cdl_regs
// configuration register file: endpoints, image size and colour
// ----------------------------------------------------------------------------
`default_nettype none

module cdl_regs #(
   parameter int COORD_BITS = cdl_pkg::COORD_BITS_DEF,
   parameter int CSR_DATA_W = cdl_pkg::COLOR_W
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [cdl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]              csr_wdata,
   output logic signed [COORD_BITS-1:0]            start_x,
   output logic signed [COORD_BITS-1:0]            start_y,
   output logic signed [COORD_BITS-1:0]            end_x,
   output logic signed [COORD_BITS-1:0]            end_y,
   output logic [cdl_pkg::DIM_W-1:0]               image_width,
   output logic [cdl_pkg::DIM_W-1:0]               image_height,
   output logic [cdl_pkg::COLOR_W-1:0]             color_rgb
);

   logic signed [COORD_BITS-1:0]   start_x_ff, start_x_in;
   logic signed [COORD_BITS-1:0]   start_y_ff, start_y_in;
   logic signed [COORD_BITS-1:0]   end_x_ff, end_x_in;
   logic signed [COORD_BITS-1:0]   end_y_ff, end_y_in;
   logic [cdl_pkg::DIM_W-1:0]      width_ff, width_in;
   logic [cdl_pkg::DIM_W-1:0]      height_ff, height_in;
   logic [cdl_pkg::COLOR_W-1:0]    color_ff, color_in;

   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      color_in   = color_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cdl_pkg::REG_START_X:      start_x_in = csr_wdata[COORD_BITS-1:0];
            cdl_pkg::REG_START_Y:      start_y_in = csr_wdata[COORD_BITS-1:0];
            cdl_pkg::REG_END_X:        end_x_in   = csr_wdata[COORD_BITS-1:0];
            cdl_pkg::REG_END_Y:        end_y_in   = csr_wdata[COORD_BITS-1:0];
            cdl_pkg::REG_IMAGE_WIDTH:  width_in   = csr_wdata[cdl_pkg::DIM_W-1:0];
            cdl_pkg::REG_IMAGE_HEIGHT: height_in  = csr_wdata[cdl_pkg::DIM_W-1:0];
            cdl_pkg::REG_COLOR_RGB:    color_in   = csr_wdata[cdl_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
         width_ff   <= cdl_pkg::WIDTH_RESET;
         height_ff  <= cdl_pkg::HEIGHT_RESET;
         color_ff   <= cdl_pkg::COLOR_RESET;
      end else begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         end_x_ff   <= end_x_in;
         end_y_ff   <= end_y_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         color_ff   <= color_in;
      end
   end

   assign start_x      = start_x_ff;
   assign start_y      = start_y_ff;
   assign end_x        = end_x_ff;
   assign end_y        = end_y_ff;
   assign image_width  = width_ff;
   assign image_height = height_ff;
   assign color_rgb    = color_ff;

endmodule

`default_nettype wire

[src/cdl_ctrl.sv]
// ----------------------------------------------------------------------------
// cdl_ctrl
// sequencer: accepts transactions, runs the slope divider and the step
// pipeline, and owns the result valid flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module cdl_ctrl #(
   parameter int SLOPE_FRAC_BITS = cdl_pkg::SLOPE_FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_restart,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cdl_pkg::cmd_type       cmd,
   input  wire cdl_pkg::stat_type stat
);

   localparam int CNT_W = $clog2(SLOPE_FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SLOPE_FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pixel_ff, pixel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pixel_in     = pixel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (req_restart) begin
                  cmd.setup = 1'b1;
                  pixel_in  = 1'b0;
                  state_in  = stat.degenerate ? ST_EMIT : ST_DIV;
               end else if (stat.active) begin
                  cmd.diff = 1'b1;
                  pixel_in = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  // no line in progress: empty result
                  pixel_in = 1'b0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cmd.div_last = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.pixel    = pixel_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pixel_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pixel_ff     <= pixel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CDL_ASSERT(a_accept_leaves_idle, clock, reset, (req_valid && !req_stall) |=> (state_ff != ST_IDLE), "accepted transaction did not start work")
   `CDL_ASSERT(a_div_count_bound, clock, reset, (state_ff == ST_DIV) |-> (cnt_ff <= DIV_LAST), "divider step count overrun")
   `CDL_ASSERT(a_emit_when_free, clock, reset, (state_ff == ST_EMIT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE), "result not issued into empty output register")

endmodule

`default_nettype wire

[src/cdl_dpath.sv]
// ----------------------------------------------------------------------------
// cdl_dpath
// line state, bit-serial slope divider, step multiplier and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module cdl_dpath #(
   parameter int COORD_BITS      = cdl_pkg::COORD_BITS_DEF,
   parameter int SLOPE_FRAC_BITS = cdl_pkg::SLOPE_FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cdl_pkg::cmd_type                cmd,
   output cdl_pkg::stat_type                    stat,
   input  wire logic signed [COORD_BITS-1:0]    start_x,
   input  wire logic signed [COORD_BITS-1:0]    start_y,
   input  wire logic signed [COORD_BITS-1:0]    end_x,
   input  wire logic signed [COORD_BITS-1:0]    end_y,
   input  wire logic [cdl_pkg::DIM_W-1:0]       image_width,
   input  wire logic [cdl_pkg::DIM_W-1:0]       image_height,
   input  wire logic [cdl_pkg::COLOR_W-1:0]     color_rgb,
   output logic [cdl_pkg::PIX_W-1:0]            rsp_pixel_x,
   output logic [cdl_pkg::PIX_W-1:0]            rsp_pixel_y,
   output logic [cdl_pkg::BYTE_W-1:0]           rsp_byte_first,
   output logic [cdl_pkg::BYTE_W-1:0]           rsp_byte_second,
   output logic [cdl_pkg::BYTE_W-1:0]           rsp_byte_third,
   output logic                                 rsp_write,
   output logic                                 rsp_done_res
);

   localparam int C       = COORD_BITS;
   localparam int F       = SLOPE_FRAC_BITS;
   localparam int DIM_W   = cdl_pkg::DIM_W;
   localparam int PIX_W   = cdl_pkg::PIX_W;
   localparam int BYTE_W  = cdl_pkg::BYTE_W;
   localparam int MAG_W   = C + 1;
   localparam int REM_W   = C + 2;
   localparam int Q_W     = F + 1;
   localparam int SLOPE_W = F + 2;
   localparam int POS_W   = ((C > DIM_W) ? C : DIM_W) + 1;
   localparam int OFS_W   = POS_W + 1;
   localparam int PROD_W  = SLOPE_W + OFS_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int MIN_W   = SUM_W - F;

   localparam logic signed [SLOPE_W-1:0] SLOPE_ONE       = SLOPE_W'(2 ** F);
   localparam logic signed [SLOPE_W-1:0] SLOPE_MINUS_ONE = -SLOPE_ONE;

   // line state
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic signed [POS_W-1:0]   limit_ff, limit_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic                      x_major_ff, x_major_in;
   logic                      active_ff, active_in;

   // divider and step pipeline
   logic [MAG_W-1:0]          den_ff, den_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic                      neg_ff, neg_in;
   logic signed [OFS_W-1:0]   ofs_ff, ofs_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;

   // result register
   logic [PIX_W-1:0]          px_ff, px_in;
   logic [PIX_W-1:0]          py_ff, py_in;
   logic [BYTE_W-1:0]         b0_ff, b0_in;
   logic [BYTE_W-1:0]         b1_ff, b1_in;
   logic [BYTE_W-1:0]         b2_ff, b2_in;
   logic                      wr_ff, wr_in;
   logic                      done_ff, done_in;

   // setup
   logic signed [MAG_W-1:0]   dx, dy;
   logic [MAG_W-1:0]          adx, ady;
   logic                      x_major_w;
   logic                      degenerate_w;

   // bounds
   logic signed [C-1:0]       s1_w, e1_w, s2_w;
   logic signed [POS_W-1:0]   s1_p, e1_p, lo_p, hi_p, ext_p;
   logic signed [POS_W-1:0]   pos_w, limit_w;
   logic [DIM_W-1:0]          ext_maj, ext_min;

   // divider
   logic [REM_W-1:0]          den_ext;
   logic                      q_bit;
   logic [REM_W-1:0]          rem_sub;
   logic [Q_W-1:0]            q_next;
   logic [SLOPE_W-1:0]        q_mag;

   // step
   logic signed [PROD_W-1:0]  prod_w;
   logic [MIN_W-1:0]          minor_w;
   logic                      round_up;
   logic                      in_image;
   logic signed [POS_W-1:0]   pos_inc;
   logic                      still_active;

   assign dx = {end_x[C-1], end_x} - {start_x[C-1], start_x};
   assign dy = {end_y[C-1], end_y} - {start_y[C-1], start_y};
   assign adx = dx[MAG_W-1] ? $unsigned(-dx) : $unsigned(dx);
   assign ady = dy[MAG_W-1] ? $unsigned(-dy) : $unsigned(dy);
   assign x_major_w    = (adx >= ady);
   assign degenerate_w = (dx == '0) && (dy == '0);

   // axis selection follows the latched major axis
   assign s1_w    = x_major_ff ? start_x : start_y;
   assign e1_w    = x_major_ff ? end_x : end_y;
   assign s2_w    = x_major_ff ? start_y : start_x;
   assign ext_maj = cdl_pkg::sat_extent(x_major_ff ? image_width : image_height);
   assign ext_min = cdl_pkg::sat_extent(x_major_ff ? image_height : image_width);

   assign s1_p    = {{(POS_W-C){s1_w[C-1]}}, s1_w};
   assign e1_p    = {{(POS_W-C){e1_w[C-1]}}, e1_w};
   assign ext_p   = {{(POS_W-DIM_W){1'b0}}, ext_maj};
   assign lo_p    = (s1_p < e1_p) ? s1_p : e1_p;
   assign hi_p    = (s1_p < e1_p) ? e1_p : s1_p;
   assign pos_w   = lo_p[POS_W-1] ? '0 : lo_p;
   assign limit_w = (hi_p < ext_p) ? hi_p : ext_p;

   // restoring division, one quotient bit per cycle
   assign den_ext = {1'b0, den_ff};
   assign q_bit   = (rem_ff >= den_ext);
   assign rem_sub = q_bit ? (rem_ff - den_ext) : rem_ff;
   assign q_next  = {q_ff[Q_W-2:0], q_bit};
   assign q_mag   = {1'b0, q_next};

   assign prod_w = slope_ff * ofs_ff;

   // truncate toward zero: floor, plus one for a negative sum with a fraction
   assign round_up = sum_ff[SUM_W-1] & (|sum_ff[F-1:0]);
   assign minor_w  = sum_ff[SUM_W-1:F] + {{(MIN_W-1){1'b0}}, round_up};
   assign in_image = !minor_w[MIN_W-1] &&
                     (minor_w[MIN_W-2:0] < {{(MIN_W-1-DIM_W){1'b0}}, ext_min});
   assign pos_inc      = pos_ff + POS_W'(1);
   assign still_active = (pos_inc < limit_ff);

   always_comb begin
      pos_in     = pos_ff;
      limit_in   = limit_ff;
      slope_in   = slope_ff;
      x_major_in = x_major_ff;
      active_in  = active_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      neg_in     = neg_ff;
      ofs_in     = ofs_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;

      if (cmd.setup) begin
         // no line in progress while the new span and slope are worked out
         active_in = 1'b0;
         if (!degenerate_w) begin
            x_major_in = x_major_w;
            den_in     = x_major_w ? adx : ady;
            rem_in     = {1'b0, (x_major_w ? ady : adx)};
            q_in       = '0;
            neg_in     = dx[MAG_W-1] ^ dy[MAG_W-1];
         end
      end
      if (cmd.div_step) begin
         pos_in   = pos_w;
         limit_in = limit_w;
         rem_in   = {rem_sub[REM_W-2:0], 1'b0};
         q_in     = q_next;
      end
      if (cmd.div_last) begin
         slope_in  = neg_ff ? (~q_mag + 1'b1) : q_mag;
         active_in = (pos_ff < limit_ff);
      end
      if (cmd.diff) begin
         ofs_in = {pos_ff[POS_W-1], pos_ff} - {{(OFS_W-C){s1_w[C-1]}}, s1_w};
      end
      if (cmd.mul) begin
         prod_in = prod_w;
      end
      if (cmd.sum) begin
         sum_in = {{(SUM_W-C-F){s2_w[C-1]}}, s2_w, {F{1'b0}}} +
                  {prod_ff[PROD_W-1], prod_ff};
      end
      if (cmd.load_rsp && cmd.pixel) begin
         pos_in    = pos_inc;
         active_in = still_active;
      end
   end

   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      b0_in   = b0_ff;
      b1_in   = b1_ff;
      b2_in   = b2_ff;
      wr_in   = wr_ff;
      done_in = done_ff;
      if (cmd.load_rsp) begin
         px_in   = '0;
         py_in   = '0;
         b0_in   = '0;
         b1_in   = '0;
         b2_in   = '0;
         wr_in   = 1'b0;
         done_in = !active_ff;
         if (cmd.pixel) begin
            done_in = !still_active;
            if (in_image) begin
               wr_in = 1'b1;
               px_in = x_major_ff ? pos_ff[PIX_W-1:0] : minor_w[PIX_W-1:0];
               py_in = x_major_ff ? minor_w[PIX_W-1:0] : pos_ff[PIX_W-1:0];
               b0_in = color_rgb[BYTE_W-1:0];
               b1_in = color_rgb[2*BYTE_W-1:BYTE_W];
               b2_in = color_rgb[3*BYTE_W-1:2*BYTE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         limit_ff   <= '0;
         slope_ff   <= '0;
         x_major_ff <= 1'b1;
         active_ff  <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         limit_ff   <= limit_in;
         slope_ff   <= slope_in;
         x_major_ff <= x_major_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      ofs_ff  <= ofs_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      b0_ff   <= b0_in;
      b1_ff   <= b1_in;
      b2_ff   <= b2_in;
      wr_ff   <= wr_in;
      done_ff <= done_in;
   end

   assign stat.degenerate = degenerate_w;
   assign stat.active     = active_ff;

   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_byte_first  = b0_ff;
   assign rsp_byte_second = b1_ff;
   assign rsp_byte_third  = b2_ff;
   assign rsp_write       = wr_ff;
   assign rsp_done_res    = done_ff;

   `CDL_ASSERT(a_active_in_range, clock, reset, active_ff |-> (pos_ff < limit_ff), "active line with position at or past its limit")
   `CDL_ASSERT(a_slope_bound, clock, reset, (slope_ff <= SLOPE_ONE) && (slope_ff >= SLOPE_MINUS_ONE), "slope magnitude above one")
   `CDL_ASSERT(a_div_remainder, clock, reset, cmd.div_step |-> (rem_ff < (den_ext << 1)), "divider remainder out of range")

endmodule

`default_nettype wire

[src/clipped_dda_line_drawer_core.sv]
// ----------------------------------------------------------------------------
// clipped_dda_line_drawer_core
// clipped DDA line rasteriser with a configured colour and image size
// ----------------------------------------------------------------------------
// A restart transaction latches the major axis, the clipped major-axis span
// and a signed slope with SLOPE_FRAC_BITS fraction bits; the slope comes from
// a restoring divider that resolves one quotient bit a cycle, and the restart
// result is loaded into the output register after the last quotient bit
// (straight after acceptance for a line with equal endpoints). Each advance
// transaction on an active line runs acceptance with the offset, slope
// multiply, sum, then truncation and clipping into the output register; an
// advance with no line in progress goes straight to the output register.
// The input is stalled after acceptance until the result is loaded, and the
// load is held for as long as the previous result is still stalled. The
// result register lets the next transaction be accepted while a result is
// still stalled. Endpoints, image size and colour are read live at each
// step; only slope, axis, position and limit are held from the restart.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_dda_line_drawer_core #(
   parameter int COORD_BITS      = cdl_pkg::COORD_BITS_DEF,
   parameter int SLOPE_FRAC_BITS = cdl_pkg::SLOPE_FRAC_BITS_DEF,
   parameter int CSR_DATA_W      = (COORD_BITS > cdl_pkg::COLOR_W) ?
                                   COORD_BITS : cdl_pkg::COLOR_W
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_restart,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [cdl_pkg::PIX_W-1:0]           rsp_pixel_x,
   output logic [cdl_pkg::PIX_W-1:0]           rsp_pixel_y,
   output logic [cdl_pkg::BYTE_W-1:0]          rsp_byte_first,
   output logic [cdl_pkg::BYTE_W-1:0]          rsp_byte_second,
   output logic [cdl_pkg::BYTE_W-1:0]          rsp_byte_third,
   output logic                                rsp_write,
   output logic                                rsp_done_res,
   input  wire logic                           csr_wr_en,
   input  wire logic [cdl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]          csr_wdata
);

   logic signed [COORD_BITS-1:0]   start_x, start_y, end_x, end_y;
   logic [cdl_pkg::DIM_W-1:0]      image_width, image_height;
   logic [cdl_pkg::COLOR_W-1:0]    color_rgb;
   cdl_pkg::cmd_type               cmd;
   cdl_pkg::stat_type              stat;

   cdl_regs #(
      .COORD_BITS (COORD_BITS),
      .CSR_DATA_W (CSR_DATA_W)
   ) u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .start_x      (start_x),
      .start_y      (start_y),
      .end_x        (end_x),
      .end_y        (end_y),
      .image_width  (image_width),
      .image_height (image_height),
      .color_rgb    (color_rgb)
   );

   cdl_ctrl #(
      .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   cdl_dpath #(
      .COORD_BITS      (COORD_BITS),
      .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .start_x         (start_x),
      .start_y         (start_y),
      .end_x           (end_x),
      .end_y           (end_y),
      .image_width     (image_width),
      .image_height    (image_height),
      .color_rgb       (color_rgb),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_byte_first  (rsp_byte_first),
      .rsp_byte_second (rsp_byte_second),
      .rsp_byte_third  (rsp_byte_third),
      .rsp_write       (rsp_write),
      .rsp_done_res    (rsp_done_res)
   );

endmodule

`default_nettype wire

[tb/clipped_dda_line_drawer_core_test.sv]
// ----------------------------------------------------------------------------
// clipped_dda_line_drawer_core_test
// self-checking bench for the clipped DDA line rasteriser
// ----------------------------------------------------------------------------
// Lines are set up through the register port while the core is idle, then
// restart and advance transactions are streamed in with random gaps. A
// rasteriser model inside the bench predicts every result at the moment its
// transaction is accepted; the monitor compares each result field by field.
// A short directed part covers empty lines, clipping, saturated and zero image
// sizes, coordinate extremes and registers changed during a line; random lines
// follow, with one long hold-off on the result side to back the core up.
// ----------------------------------------------------------------------------

module clipped_dda_line_drawer_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_W      = cdl_pkg::COLOR_W;
   localparam int FRAC       = cdl_pkg::SLOPE_FRAC_BITS_DEF;
   localparam int PIX_W      = cdl_pkg::PIX_W;
   localparam int BYTE_W     = cdl_pkg::BYTE_W;
   localparam int DIM_W      = cdl_pkg::DIM_W;
   localparam int COLOR_W    = cdl_pkg::COLOR_W;
   localparam int IDX_W      = cdl_pkg::CSR_IDX_W;
   localparam longint ONE    = longint'(1) << FRAC;
   localparam int STEP_COUNT = 1050;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_x;
      logic [PIX_W-1:0]  pixel_y;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
      logic              write_en;
      logic              done;
   } drawn_pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIX_W-1:0]     rsp_pixel_x;
   logic [PIX_W-1:0]     rsp_pixel_y;
   logic [BYTE_W-1:0]    rsp_byte_first;
   logic [BYTE_W-1:0]    rsp_byte_second;
   logic [BYTE_W-1:0]    rsp_byte_third;
   logic                 rsp_write;
   logic                 rsp_done_res;
   logic                 csr_wr_en = 1'b0;
   logic [IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // register copies as the core holds them
   logic signed [15:0]   line_start_x = '0;
   logic signed [15:0]   line_start_y = '0;
   logic signed [15:0]   line_end_x = '0;
   logic signed [15:0]   line_end_y = '0;
   logic [DIM_W-1:0]     image_w = cdl_pkg::WIDTH_RESET;
   logic [DIM_W-1:0]     image_h = cdl_pkg::HEIGHT_RESET;
   logic [COLOR_W-1:0]   line_colour = cdl_pkg::COLOR_RESET;

   // rasteriser state latched at restart
   longint               major_pos = 0;
   longint               major_end = 0;
   longint               slope_q16 = 0;
   bit                   x_major = 1'b1;
   bit                   line_live = 1'b0;

   bit                   step_requests[$];
   drawn_pixel_type      pixels_due[$];
   int                   mismatches = 0;
   int                   steps_queued = 0;
   int                   cycle_count = 0;
   int                   send_gap = 0;
   int                   send_calm = 0;
   int                   stall_left = 0;
   int                   stall_calm = 0;
   int                   hold_left = 0;
   bit                   hold_done = 1'b0;
   bit                   next_valid;
   bit                   next_restart;
   drawn_pixel_type      seen;
   drawn_pixel_type      want;

   clipped_dda_line_drawer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_byte_first  (rsp_byte_first),
      .rsp_byte_second (rsp_byte_second),
      .rsp_byte_third  (rsp_byte_third),
      .rsp_write       (rsp_write),
      .rsp_done_res    (rsp_done_res),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // low phase first so the first rising edge is well after time zero
   always begin
      #1;
      clock = 1'b1;
      #1;
      clock = 1'b0;
   end

   function automatic longint clip_extent(input logic [DIM_W-1:0] v);
      return (v > 13'd4096) ? 4096 : longint'(v);
   endfunction

   // one restart or advance of the rasteriser
   function automatic drawn_pixel_type rasterise_step(input bit restart);
      drawn_pixel_type r;
      longint sx, sy, ex, ey, dx, dy, s1, e1, s2, ext, ext2, lo, hi, sum, minor;
      r = '0;
      sx = longint'(line_start_x);
      sy = longint'(line_start_y);
      ex = longint'(line_end_x);
      ey = longint'(line_end_y);
      if (restart) begin
         dx = ex - sx;
         dy = ey - sy;
         if (dx == 0 && dy == 0) begin
            line_live = 1'b0;
         end else begin
            if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
               x_major = 1'b1;
               slope_q16 = (dy * ONE) / dx;
               s1 = sx;
               e1 = ex;
               ext = clip_extent(image_w);
            end else begin
               x_major = 1'b0;
               slope_q16 = (dx * ONE) / dy;
               s1 = sy;
               e1 = ey;
               ext = clip_extent(image_h);
            end
            lo = (s1 < e1) ? s1 : e1;
            hi = (s1 < e1) ? e1 : s1;
            major_pos = (lo > 0) ? lo : 0;
            major_end = (hi < ext) ? hi : ext;
            line_live = major_pos < major_end;
         end
      end else if (line_live) begin
         s1 = x_major ? sx : sy;
         s2 = x_major ? sy : sx;
         ext2 = x_major ? clip_extent(image_h) : clip_extent(image_w);
         sum = s2 * ONE + slope_q16 * (major_pos - s1);
         minor = sum / ONE;
         if (minor >= 0 && minor < ext2) begin
            r.write_en = 1'b1;
            r.pixel_x = x_major ? major_pos[PIX_W-1:0] : minor[PIX_W-1:0];
            r.pixel_y = x_major ? minor[PIX_W-1:0] : major_pos[PIX_W-1:0];
            r.blue = line_colour[7:0];
            r.green = line_colour[15:8];
            r.red = line_colour[23:16];
         end
         major_pos++;
         if (major_pos >= major_end)
            line_live = 1'b0;
      end
      r.done = !line_live;
      return r;
   endfunction

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int idle_length(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3)
         calm = $urandom_range(20, 80);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [CSR_W-1:0] pick_coord();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         v = int'($urandom_range(0, 90)) - 20;
         return v[CSR_W-1:0];
      end
      if (r < 82) begin
         case ($urandom_range(0, 3))
            0: return 24'h008000;
            1: return 24'h007FFF;
            2: return 24'h00FFFF;
            default: return 24'h000000;
         endcase
      end
      return CSR_W'($urandom);
   endfunction

   function automatic logic [CSR_W-1:0] pick_extent();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return CSR_W'($urandom_range(1, 48));
      if (r < 75)
         return '0;
      if (r < 87)
         return CSR_W'($urandom_range(4096, 8191));
      return CSR_W'($urandom);
   endfunction

   task automatic report(input string msg);
      mismatches++;
      $display("[%0t] %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp);
      if (got !== exp)
         report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, exp));
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         cdl_pkg::REG_START_X:      line_start_x = value[15:0];
         cdl_pkg::REG_START_Y:      line_start_y = value[15:0];
         cdl_pkg::REG_END_X:        line_end_x = value[15:0];
         cdl_pkg::REG_END_Y:        line_end_y = value[15:0];
         cdl_pkg::REG_IMAGE_WIDTH:  image_w = value[DIM_W-1:0];
         cdl_pkg::REG_IMAGE_HEIGHT: image_h = value[DIM_W-1:0];
         cdl_pkg::REG_COLOR_RGB:    line_colour = value[COLOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_step(input bit restart);
      step_requests.push_back(restart);
      steps_queued++;
   endtask

   task automatic queue_advances(input int n);
      repeat (n) queue_step(1'b0);
   endtask

   // core is idle once every transaction is in and every pixel is out;
   // sampled mid-cycle so the edge-time queue updates have all settled
   task automatic wait_idle();
      do
         @(negedge clock);
      while (step_requests.size() != 0 || req_valid || pixels_due.size() != 0);
   endtask

   // driver: one nonblocking update per signal per edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_restart <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_restart = req_restart;
         if (req_valid && !req_stall) begin
            pixels_due.push_back(rasterise_step(req_restart));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (step_requests.size() > 0) begin
               next_restart = step_requests.pop_front();
               next_valid = 1'b1;
               send_gap = idle_length(send_calm);
            end
         end
         req_valid <= next_valid;
         req_restart <= next_restart;
      end
   end

   // result side stalls, plus one long hold-off while transactions queue up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && step_requests.size() > 8) begin
         hold_done = 1'b1;
         hold_left = 150;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = idle_length(stall_calm);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_pixel_x, rsp_pixel_y, rsp_byte_first, rsp_byte_second,
                  rsp_byte_third, rsp_write, rsp_done_res};
         if (pixels_due.size() == 0) begin
            report("result transaction with no prediction waiting");
         end else begin
            want = pixels_due.pop_front();
            check_field("pixel_x", seen.pixel_x, want.pixel_x);
            check_field("pixel_y", seen.pixel_y, want.pixel_y);
            check_field("byte_first", seen.blue, want.blue);
            check_field("byte_second", seen.green, want.green);
            check_field("byte_third", seen.red, want.red);
            check_field("write", seen.write_en, want.write_en);
            check_field("done_res", seen.done, want.done);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int kind;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // advance with no line, then an empty line from the reset registers
      queue_step(1'b0);
      queue_step(1'b1);
      queue_step(1'b0);

      // shallow x-major line, stepped past its end
      wait_idle();
      write_reg(cdl_pkg::REG_START_X, 24'd2);
      write_reg(cdl_pkg::REG_START_Y, 24'd3);
      write_reg(cdl_pkg::REG_END_X, 24'd6);
      write_reg(cdl_pkg::REG_END_Y, 24'd5);
      write_reg(cdl_pkg::REG_COLOR_RGB, 24'h123456);
      end_writes();
      queue_step(1'b1);
      queue_advances(5);

      // steep line drawn backwards, clipped by the image height
      wait_idle();
      write_reg(cdl_pkg::REG_START_X, 24'd9);
      write_reg(cdl_pkg::REG_START_Y, 24'd12);
      write_reg(cdl_pkg::REG_END_X, 24'd4);
      write_reg(cdl_pkg::REG_END_Y, 24'd2);
      write_reg(cdl_pkg::REG_IMAGE_HEIGHT, 24'd5);
      end_writes();
      queue_step(1'b1);
      queue_advances(3);

      // coordinate extremes, zero height so nothing is inside
      wait_idle();
      write_reg(cdl_pkg::REG_START_X, 24'h008000);
      write_reg(cdl_pkg::REG_START_Y, 24'd0);
      write_reg(cdl_pkg::REG_END_X, 24'h007FFF);
      write_reg(cdl_pkg::REG_END_Y, 24'd0);
      write_reg(cdl_pkg::REG_IMAGE_WIDTH, 24'd3);
      write_reg(cdl_pkg::REG_IMAGE_HEIGHT, 24'd0);
      end_writes();
      queue_step(1'b1);
      queue_advances(3);

      // saturated width, pixels at the far image corner
      wait_idle();
      write_reg(cdl_pkg::REG_START_X, 24'd4094);
      write_reg(cdl_pkg::REG_START_Y, 24'd4095);
      write_reg(cdl_pkg::REG_END_X, 24'd32767);
      write_reg(cdl_pkg::REG_END_Y, 24'd4095);
      write_reg(cdl_pkg::REG_IMAGE_WIDTH, 24'd8191);
      write_reg(cdl_pkg::REG_IMAGE_HEIGHT, 24'd4096);
      write_reg(cdl_pkg::REG_COLOR_RGB, 24'hA5C30F);
      end_writes();
      queue_step(1'b1);
      queue_advances(2);

      // unmapped index ignored; colour and start changed mid-line
      wait_idle();
      write_reg(cdl_pkg::REG_START_X, 24'd0);
      write_reg(cdl_pkg::REG_START_Y, 24'd0);
      write_reg(cdl_pkg::REG_END_X, 24'd4);
      write_reg(cdl_pkg::REG_END_Y, 24'd1);
      write_reg(cdl_pkg::REG_IMAGE_WIDTH, 24'd640);
      write_reg(cdl_pkg::REG_IMAGE_HEIGHT, 24'd480);
      write_reg(REG_UNUSED, 24'hFFFFFF);
      end_writes();
      queue_step(1'b1);
      queue_advances(2);
      wait_idle();
      write_reg(cdl_pkg::REG_COLOR_RGB, 24'h00FF00);
      write_reg(cdl_pkg::REG_START_Y, 24'd7);
      end_writes();
      queue_advances(3);

      while (steps_queued < STEP_COUNT) begin
         wait_idle();
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 2) != 0) write_reg(cdl_pkg::REG_START_X, pick_coord());
            if ($urandom_range(0, 2) != 0) write_reg(cdl_pkg::REG_START_Y, pick_coord());
            if ($urandom_range(0, 2) != 0) write_reg(cdl_pkg::REG_END_X, pick_coord());
            if ($urandom_range(0, 2) != 0) write_reg(cdl_pkg::REG_END_Y, pick_coord());
            if ($urandom_range(0, 3) == 0)
               write_reg(cdl_pkg::REG_IMAGE_WIDTH, pick_extent());
            if ($urandom_range(0, 3) == 0)
               write_reg(cdl_pkg::REG_IMAGE_HEIGHT, pick_extent());
            if ($urandom_range(0, 2) == 0)
               write_reg(cdl_pkg::REG_COLOR_RGB, CSR_W'($urandom));
            if ($urandom_range(0, 19) == 0) write_reg(REG_UNUSED, CSR_W'($urandom));
            end_writes();
         end
         kind = $urandom_range(0, 9);
         if (kind < 8) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(8, 60);
            queue_step(1'b1);
            queue_advances(n);
         end else if (kind == 8) begin
            // noise: restarts and advances in any order
            repeat ($urandom_range(1, 20)) queue_step(1'(($urandom_range(0, 2)) == 0));
         end else begin
            // carry on the current line under the new registers
            queue_advances($urandom_range(1, 20));
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (pixels_due.size() != 0)
         report($sformatf("%0d predicted results never arrived", pixels_due.size()));
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/cdl_pkg.sv
src/cdl_regs.sv
src/cdl_ctrl.sv
src/cdl_dpath.sv
src/clipped_dda_line_drawer_core.sv
tb/clipped_dda_line_drawer_core_test.sv
